FILE: rtl/staggered_flow_direction_stencil_unit_macros.svh
// Assertion macros shared by the RTL of the stencil unit.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef STAGGERED_FLOW_DIRECTION_STENCIL_UNIT_MACROS_SVH
`define STAGGERED_FLOW_DIRECTION_STENCIL_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFDS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stencil unit assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stencil unit assertion failed");

`endif

FILE: rtl/sfds_pkg.sv
package sfds_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_INV_SPACING_X   = 3'd2;
    localparam logic [2:0] REG_INV_SPACING_Y   = 3'd3;
    localparam logic [2:0] REG_DENSITY_GRAVITY = 3'd4;
    localparam logic [2:0] REG_MASK_ENABLE     = 3'd5;

    localparam logic [10:0] FRAME_DIM_RESET = 11'd1024;
    localparam logic [31:0] INV_SPACING_RESET = 32'd4294967;
    localparam logic [15:0] DENSITY_GRAVITY_RESET = 16'd9810;

    // Unit length in Q1.14.
    localparam logic [14:0] Q_ONE = 15'd16384;

    // Scaled gradient term and its product with a reciprocal spacing.
    localparam int TERM_W = 54;
    localparam int PROD_W = 86;

    typedef struct packed {
        logic               m;
        logic signed [31:0] b;
        logic signed [31:0] p;
        logic signed [31:0] wn;
        logic signed [31:0] we;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_MID,
        ST_WRITE,
        ST_GRAD,
        ST_FACE,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_BIS_A,
        ST_BIS_B,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/sfds_ram.sv
module sfds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/staggered_flow_direction_stencil_unit.sv
// Flow-direction stencil on a staggered grid. Cells enter in raster order, one word at a
// time; the two previous rows sit in one line-store RAM that is read twice and written once
// per cell, and a 3x3 window of registers holds the neighborhood. For each interior cell the
// unit returns the Q1.14 unit-direction components on the east and north faces; halo cells
// return nothing. An interior cell goes through fetch, gradient and output work plus one
// decision per face. A wet, unmasked face adds the products on the shared 32x32 multiplier,
// normalizing shifts, a squaring step and up to 15 bisection steps and a closing check for
// the root and quotient. One cell is in work at a time, and the next is taken while a
// finished result waits on the output.
`include "staggered_flow_direction_stencil_unit_macros.svh"

module staggered_flow_direction_stencil_unit #(
    parameter int MAX_WIDTH  = sfds_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = sfds_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // water_east_face[31:0], water_north_face[63:32], water_pressure[95:64],
    // bed_elevation[127:96]
    input  logic [127:0] s_tdata,
    // outside_model[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // direction_east[15:0], direction_north[31:16], cell_column[41:32], cell_row[51:42],
    // zero fill [55:52]
    output logic [55:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);
    localparam int TW = sfds_pkg::TERM_W;
    localparam int PW = sfds_pkg::PROD_W;

    function automatic logic signed [TW-1:0] sx(input logic signed [31:0] v);
        return TW'(v);
    endfunction

    // Configuration.
    logic [10:0] fw_reg, fh_reg;
    logic [31:0] invx_reg, invy_reg;
    logic [15:0] rg_reg;
    logic        mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg   <= sfds_pkg::FRAME_DIM_RESET;
            fh_reg   <= sfds_pkg::FRAME_DIM_RESET;
            invx_reg <= sfds_pkg::INV_SPACING_RESET;
            invy_reg <= sfds_pkg::INV_SPACING_RESET;
            rg_reg   <= sfds_pkg::DENSITY_GRAVITY_RESET;
            mask_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sfds_pkg::REG_FRAME_WIDTH:     fw_reg   <= cfg_data[10:0];
                sfds_pkg::REG_FRAME_HEIGHT:    fh_reg   <= cfg_data[10:0];
                sfds_pkg::REG_INV_SPACING_X:   invx_reg <= cfg_data;
                sfds_pkg::REG_INV_SPACING_Y:   invy_reg <= cfg_data;
                sfds_pkg::REG_DENSITY_GRAVITY: rg_reg   <= cfg_data[15:0];
                sfds_pkg::REG_MASK_ENABLE:     mask_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Frame size clamped to the legal range.
    logic [CW-1:0] w;
    logic [RW-1:0] h;

    always_comb begin
        if (fw_reg < 11'd3) begin
            w = CW'(3);
        end else if (13'(fw_reg) > 13'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(fw_reg);
        end
        if (fh_reg < 11'd3) begin
            h = RW'(3);
        end else if (13'(fh_reg) > 13'(MAX_HEIGHT)) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(fh_reg);
        end
    end

    // Datapath and control registers.
    sfds_pkg::state_t state_reg, state_next;
    logic [CW-1:0] col_reg, col_next, c_reg, c_next;
    logic [RW-1:0] row_reg, row_next, r_reg, r_next;
    sfds_pkg::cell_t cur_reg, cur_next, old_reg, old_next;
    sfds_pkg::cell_t win_reg [3][3];
    sfds_pkg::cell_t win_next [3][3];
    logic signed [TW-1:0] term_reg [4];
    logic signed [TW-1:0] term_next [4];
    logic [1:0]  gidx_reg, gidx_next, step_reg, step_next;
    logic        face_reg, face_next, neg_reg, neg_next;
    logic [PW-1:0] psel_reg, psel_next, poth_reg, poth_next;
    logic [32:0] s2_reg, s2_next;
    logic [61:0] rhs_reg, rhs_next;
    logic [14:0] qlo_reg, qlo_next, qhi_reg, qhi_next, mid_reg, mid_next;
    logic [29:0] tt_reg, tt_next;
    logic [15:0] de_reg, de_next, dn_reg, dn_next;
    logic        ovalid_reg, ovalid_next, olast_reg, olast_next;
    logic [51:0] odata_reg, odata_next;

    // Line store.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [sfds_pkg::CELL_W-1:0] ram_rdata;

    sfds_ram #(
        .WIDTH (sfds_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == sfds_pkg::ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, odata_reg};
    assign m_tlast  = olast_reg;

    // Position of an arriving cell, including recovery from a shrunk frame.
    logic [CW-1:0] c0;
    logic [RW-1:0] r1, r0;
    logic [CW-1:0] cinc;
    logic [RW-1:0] rinc;

    always_comb begin
        if (col_reg >= w) begin
            c0 = '0;
            r1 = row_reg + RW'(1);
        end else begin
            c0 = col_reg;
            r1 = row_reg;
        end
        r0   = (r1 >= h) ? '0 : r1;
        cinc = c0 + CW'(1);
        rinc = r0 + RW'(1);
    end

    // Gradient terms for the current window.
    sfds_pkg::cell_t ce, ea, wc, no, so, ne, se, nw;
    logic signed [TW-1:0] ga, gb, gprod, gterm;
    logic signed [36:0]   gb37;
    logic signed [16:0]   rgs;

    always_comb begin
        ce = win_reg[1][1];
        ea = win_reg[1][2];
        wc = win_reg[1][0];
        no = win_reg[2][1];
        so = win_reg[0][1];
        ne = win_reg[2][2];
        se = win_reg[0][2];
        nw = win_reg[2][0];
        case (gidx_reg)
            2'd0: begin
                ga = (sx(ea.p) - sx(ce.p)) <<< 18;
                gb = ((sx(ea.b) - sx(ce.b)) <<< 2) + ((sx(ea.we) - sx(wc.we)) <<< 1);
            end
            2'd1: begin
                ga = (sx(ne.p) + sx(no.p) - sx(se.p) - sx(so.p)) <<< 16;
                gb = (sx(ne.b) + sx(no.b) - sx(se.b) - sx(so.b))
                     + ((sx(no.we) - sx(so.we)) <<< 1);
            end
            2'd2: begin
                ga = (sx(ne.p) + sx(ea.p) - sx(nw.p) - sx(wc.p)) <<< 16;
                gb = (sx(ne.b) + sx(ea.b) - sx(nw.b) - sx(wc.b))
                     + ((sx(ea.wn) - sx(wc.wn)) <<< 1);
            end
            default: begin
                ga = (sx(no.p) - sx(ce.p)) <<< 18;
                gb = ((sx(no.b) - sx(ce.b)) <<< 2) + ((sx(no.wn) - sx(so.wn)) <<< 1);
            end
        endcase
        gb37  = gb[36:0];
        rgs   = $signed({1'b0, rg_reg});
        gprod = rgs * gb37;
        gterm = -(ga + gprod);
    end

    // Shared multiplier operands for the scaled products.
    logic signed [TW-1:0] tsel, toth, tcur;
    logic [TW-1:0] tmag;
    logic [31:0]   mop, mk;
    logic [63:0]   mprod;
    logic [PW-1:0] orv;
    logic [15:0]   ms, mo;
    logic [31:0]   msq, mosq;
    logic [15:0]   msum;
    logic [14:0]   tval;
    logic [62:0]   qprod;
    logic          face_skip;
    logic [15:0]   face_res;

    always_comb begin
        tsel = face_reg ? term_reg[3] : term_reg[0];
        toth = face_reg ? term_reg[2] : term_reg[1];
        tcur = step_reg[1] ? toth : tsel;
        tmag = tcur[TW-1] ? TW'(-tcur) : TW'(tcur);
        mop  = step_reg[0] ? 32'(tmag[TW-1:32]) : tmag[31:0];
        mk   = (step_reg[1] ^ face_reg) ? invy_reg : invx_reg;
        mprod = 64'(mop) * 64'(mk);
        orv  = psel_reg | poth_reg;
        ms   = psel_reg[15:0];
        mo   = poth_reg[15:0];
        msq  = 32'(ms) * 32'(ms);
        mosq = 32'(mo) * 32'(mo);
        msum = 16'(qlo_reg) + 16'(qhi_reg) + 16'd1;
        tval = 15'({mid_reg, 1'b0} - 16'd1);
        qprod = 63'(tt_reg) * 63'(s2_reg);
        if (face_reg) begin
            face_skip = ce.wn[31] || (ce.wn == '0) || (mask_reg && (ce.m || no.m));
        end else begin
            face_skip = ce.we[31] || (ce.we == '0) || (mask_reg && (ce.m || ea.m));
        end
        face_res = (neg_reg && (qlo_reg != '0)) ? 16'(~{1'b0, qlo_reg} + 16'd1)
                                                : 16'(qlo_reg);
    end

    always_comb begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        c_next      = c_reg;
        r_next      = r_reg;
        cur_next    = cur_reg;
        old_next    = old_reg;
        win_next    = win_reg;
        term_next   = term_reg;
        gidx_next   = gidx_reg;
        step_next   = step_reg;
        face_next   = face_reg;
        neg_next    = neg_reg;
        psel_next   = psel_reg;
        poth_next   = poth_reg;
        s2_next     = s2_reg;
        rhs_next    = rhs_reg;
        qlo_next    = qlo_reg;
        qhi_next    = qhi_reg;
        mid_next    = mid_reg;
        tt_next     = tt_reg;
        de_next     = de_reg;
        dn_next     = dn_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ram_we      = 1'b0;
        ram_waddr   = r_reg[0] ? AW'(MAX_WIDTH) + AW'(c_reg) : AW'(c_reg);
        ram_raddr   = r0[0] ? AW'(MAX_WIDTH) + AW'(c0) : AW'(c0);

        unique case (state_reg)
            sfds_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    c_next   = c0;
                    r_next   = r0;
                    cur_next = '{m: s_tuser, b: s_tdata[127:96], p: s_tdata[95:64],
                                 wn: s_tdata[63:32], we: s_tdata[31:0]};
                    if (cinc >= w) begin
                        col_next = '0;
                        row_next = (rinc >= h) ? '0 : rinc;
                    end else begin
                        col_next = cinc;
                        row_next = r0;
                    end
                    state_next = sfds_pkg::ST_RD_MID;
                end
            end
            sfds_pkg::ST_RD_MID: begin
                old_next   = ram_rdata;
                ram_raddr  = r_reg[0] ? AW'(c_reg) : AW'(MAX_WIDTH) + AW'(c_reg);
                state_next = sfds_pkg::ST_WRITE;
            end
            sfds_pkg::ST_WRITE: begin
                ram_we = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    win_next[k][0] = win_reg[k][1];
                    win_next[k][1] = win_reg[k][2];
                end
                win_next[0][2] = old_reg;
                win_next[1][2] = ram_rdata;
                win_next[2][2] = cur_reg;
                gidx_next = '0;
                face_next = 1'b0;
                if (c_reg >= CW'(2) && r_reg >= RW'(2)) begin
                    state_next = sfds_pkg::ST_GRAD;
                end else begin
                    state_next = sfds_pkg::ST_IDLE;
                end
            end
            sfds_pkg::ST_GRAD: begin
                term_next[gidx_reg] = gterm;
                gidx_next = gidx_reg + 2'd1;
                if (gidx_reg == 2'd3) begin
                    state_next = sfds_pkg::ST_FACE;
                end
            end
            sfds_pkg::ST_FACE: begin
                if (face_skip) begin
                    if (face_reg) begin
                        dn_next    = '0;
                        state_next = sfds_pkg::ST_OUT;
                    end else begin
                        de_next   = '0;
                        face_next = 1'b1;
                    end
                end else begin
                    step_next  = '0;
                    neg_next   = tsel[TW-1];
                    state_next = sfds_pkg::ST_MUL;
                end
            end
            sfds_pkg::ST_MUL: begin
                case (step_reg)
                    2'd0: psel_next = PW'(mprod);
                    2'd1: psel_next = psel_reg + (PW'(mprod) << 32);
                    2'd2: poth_next = PW'(mprod);
                    default: poth_next = poth_reg + (PW'(mprod) << 32);
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = sfds_pkg::ST_NORM;
                end
            end
            sfds_pkg::ST_NORM: begin
                // Coarse steps only while the result stays at least 16 bits wide.
                if (|orv[PW-1:32]) begin
                    psel_next = psel_reg >> 16;
                    poth_next = poth_reg >> 16;
                end else if (|orv[PW-1:16]) begin
                    psel_next = psel_reg >> 1;
                    poth_next = poth_reg >> 1;
                end else begin
                    state_next = sfds_pkg::ST_SQ;
                end
            end
            sfds_pkg::ST_SQ: begin
                s2_next    = 33'(msq) + 33'(mosq);
                rhs_next   = {msq, 30'd0};
                qlo_next   = '0;
                qhi_next   = sfds_pkg::Q_ONE;
                state_next = sfds_pkg::ST_BIS_A;
            end
            sfds_pkg::ST_BIS_A: begin
                if (s2_reg == '0) begin
                    qlo_next = '0;
                end
                if (s2_reg != '0 && qlo_reg < qhi_reg) begin
                    mid_next   = msum[15:1];
                    state_next = sfds_pkg::ST_BIS_B;
                end else if (face_reg) begin
                    dn_next    = (s2_reg == '0) ? '0 : face_res;
                    state_next = sfds_pkg::ST_OUT;
                end else begin
                    de_next    = (s2_reg == '0) ? '0 : face_res;
                    face_next  = 1'b1;
                    state_next = sfds_pkg::ST_FACE;
                end
            end
            sfds_pkg::ST_BIS_B: begin
                // The first step squares the odd bound, the second weighs it.
                if (step_reg == 2'd0) begin
                    tt_next   = 30'(tval) * 30'(tval);
                    step_next = 2'd1;
                end else begin
                    step_next = 2'd0;
                    if (qprod <= 63'(rhs_reg)) begin
                        qlo_next = mid_reg;
                    end else begin
                        qhi_next = mid_reg - 15'd1;
                    end
                    state_next = sfds_pkg::ST_BIS_A;
                end
            end
            sfds_pkg::ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    odata_next  = {10'(r_reg - RW'(1)), 10'(c_reg - CW'(1)), dn_reg, de_reg};
                    olast_next  = (c_reg == w - CW'(1)) && (r_reg == h - RW'(1));
                    state_next  = sfds_pkg::ST_IDLE;
                end
            end
            default: state_next = sfds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sfds_pkg::ST_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
            step_reg   <= step_next;
            win_reg    <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg     <= c_next;
        r_reg     <= r_next;
        cur_reg   <= cur_next;
        old_reg   <= old_next;
        term_reg  <= term_next;
        gidx_reg  <= gidx_next;
        face_reg  <= face_next;
        neg_reg   <= neg_next;
        psel_reg  <= psel_next;
        poth_reg  <= poth_next;
        s2_reg    <= s2_next;
        rhs_reg   <= rhs_next;
        qlo_reg   <= qlo_next;
        qhi_reg   <= qhi_next;
        mid_reg   <= mid_next;
        tt_reg    <= tt_next;
        de_reg    <= de_next;
        dn_reg    <= dn_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    `SFDS_ASSERT_NEXT(a_accept_fetch, s_tvalid && s_tready, state_reg == sfds_pkg::ST_RD_MID)
    `SFDS_ASSERT_NEXT(a_out_holds, state_reg == sfds_pkg::ST_OUT && ovalid_reg && !m_tready,
        state_reg == sfds_pkg::ST_OUT)
    `SFDS_ASSERT_SAME(a_norm_done, state_reg == sfds_pkg::ST_SQ,
        psel_reg[PW-1:16] == '0 && poth_reg[PW-1:16] == '0)
    `SFDS_ASSERT_SAME(a_bisect_range, state_reg == sfds_pkg::ST_BIS_B,
        qlo_reg <= sfds_pkg::Q_ONE && qhi_reg <= sfds_pkg::Q_ONE)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  DRAIN_WAIT = 200;
    localparam int  STORE_SIZE = 2 * sfds_pkg::MAX_WIDTH_DEFAULT;

    typedef struct packed {
        logic [127:0] data;
        logic         flag;
    } cell_word_t;

    typedef struct packed {
        logic [15:0] de;
        logic [15:0] dn;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
    } direction_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    staggered_flow_direction_stencil_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration and of the stencil state.
    logic [10:0]  frame_w = sfds_pkg::FRAME_DIM_RESET;
    logic [10:0]  frame_h = sfds_pkg::FRAME_DIM_RESET;
    logic [31:0]  inv_dx = sfds_pkg::INV_SPACING_RESET;
    logic [31:0]  inv_dy = sfds_pkg::INV_SPACING_RESET;
    logic [15:0]  rho_g = sfds_pkg::DENSITY_GRAVITY_RESET;
    logic         mask_on = 1'b0;
    sfds_pkg::cell_t line_store [STORE_SIZE];
    sfds_pkg::cell_t window [3][3];
    int           col_pos = 0;
    int           row_pos = 0;

    cell_word_t   cell_q [$];
    direction_t   direction_q [$];
    int           errors = 0;
    int           cycles = 0;
    bit           no_gaps = 0;
    int           send_gap = 0;
    int           recv_gap = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 200);
    endfunction

    function automatic int clamp_dim(logic [10:0] v);
        if (v < 3) return 3;
        if (v > sfds_pkg::MAX_WIDTH_DEFAULT) return sfds_pkg::MAX_WIDTH_DEFAULT;
        return v;
    endfunction

    function automatic longint sx(logic signed [31:0] v);
        return v;
    endfunction

    function automatic int bit_length(logic [127:0] v);
        for (int i = 127; i >= 0; i--) begin
            if (v[i]) return i + 1;
        end
        return 0;
    endfunction

    // Q1.14 component sel / |(sel, oth)| after the common truncating shift.
    function automatic logic [15:0] unit_component(longint sel, logic [31:0] ks,
                                                   longint oth, logic [31:0] ko);
        logic [63:0]      mag_s, mag_o;
        logic [127:0]     ps, po;
        longint unsigned  ms, mo, s2, rhs, t;
        int               len, sh, qlo, qhi, mid;
        bit               neg;
        neg = sel < 0;
        mag_s = neg ? 64'(-sel) : 64'(sel);
        mag_o = (oth < 0) ? 64'(-oth) : 64'(oth);
        ps = {64'd0, mag_s} * {96'd0, ks};
        po = {64'd0, mag_o} * {96'd0, ko};
        len = bit_length(ps);
        if (bit_length(po) > len) len = bit_length(po);
        sh = (len > 16) ? len - 16 : 0;
        ms = 64'(ps >> sh);
        mo = 64'(po >> sh);
        s2 = ms * ms + mo * mo;
        if (s2 == 0) return 16'd0;
        rhs = (ms * ms) << 30;
        qlo = 0;
        qhi = 16384;
        while (qlo < qhi) begin
            mid = (qlo + qhi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * s2 <= rhs) qlo = mid;
            else qhi = mid - 1;
        end
        if (neg && qlo != 0) return 16'(17'h10000 - qlo);
        return 16'(qlo);
    endfunction

    task automatic predict_cell(cell_word_t wd);
        sfds_pkg::cell_t cur, ce, e, wc, n, s, ne, se, nw;
        int         w, h, c, r, iold, imid;
        longint     ux, vy, g;
        direction_t res;
        w = clamp_dim(frame_w);
        h = clamp_dim(frame_h);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        cur.we = wd.data[31:0];
        cur.wn = wd.data[63:32];
        cur.p = wd.data[95:64];
        cur.b = wd.data[127:96];
        cur.m = wd.flag;
        iold = (r % 2) * sfds_pkg::MAX_WIDTH_DEFAULT + c;
        imid = ((r + 1) % 2) * sfds_pkg::MAX_WIDTH_DEFAULT + c;
        for (int k = 0; k < 3; k++) begin
            window[k][0] = window[k][1];
            window[k][1] = window[k][2];
        end
        window[0][2] = line_store[iold];
        window[1][2] = line_store[imid];
        window[2][2] = cur;
        line_store[iold] = cur;
        if (c >= 2 && r >= 2) begin
            ce = window[1][1]; e = window[1][2]; wc = window[1][0];
            n = window[2][1]; s = window[0][1];
            ne = window[2][2]; se = window[0][2]; nw = window[2][0];
            g = rho_g;
            res.de = '0;
            res.dn = '0;
            if (sx(ce.we) > 0) begin
                ux = -(262144 * (sx(e.p) - sx(ce.p))
                       + g * (4 * (sx(e.b) - sx(ce.b)) + 2 * (sx(e.we) - sx(wc.we))));
                vy = -(65536 * (sx(ne.p) + sx(n.p) - sx(se.p) - sx(s.p))
                       + g * ((sx(ne.b) + sx(n.b) - sx(se.b) - sx(s.b))
                              + 2 * (sx(n.we) - sx(s.we))));
                res.de = unit_component(ux, inv_dx, vy, inv_dy);
            end
            if (mask_on && (ce.m || e.m)) res.de = '0;
            if (sx(ce.wn) > 0) begin
                ux = -(65536 * (sx(ne.p) + sx(e.p) - sx(nw.p) - sx(wc.p))
                       + g * ((sx(ne.b) + sx(e.b) - sx(nw.b) - sx(wc.b))
                              + 2 * (sx(e.wn) - sx(wc.wn))));
                vy = -(262144 * (sx(n.p) - sx(ce.p))
                       + g * (4 * (sx(n.b) - sx(ce.b)) + 2 * (sx(n.wn) - sx(s.wn))));
                res.dn = unit_component(vy, inv_dy, ux, inv_dx);
            end
            if (mask_on && (ce.m || n.m)) res.dn = '0;
            res.col = 10'(c - 1);
            res.row = 10'(r - 1);
            res.last = (c == w - 1 && r == h - 1);
            direction_q.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Cell word driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_cell({s_tdata, s_tuser});
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (cell_q.size() != 0) begin
                    cell_word_t wd;
                    wd = cell_q.pop_front();
                    s_tdata <= wd.data;
                    s_tuser <= wd.flag;
                    s_tvalid <= 1'b1;
                    send_gap = gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (direction_q.size() == 0) begin
                    report("pending result words", 1, 0);
                end else begin
                    direction_t want;
                    want = direction_q.pop_front();
                    if (m_tdata[15:0] != want.de)
                        report("direction_east", $signed(m_tdata[15:0]), $signed(want.de));
                    if (m_tdata[31:16] != want.dn)
                        report("direction_north", $signed(m_tdata[31:16]), $signed(want.dn));
                    if (m_tdata[41:32] != want.col) report("cell_column", m_tdata[41:32], want.col);
                    if (m_tdata[51:42] != want.row) report("cell_row", m_tdata[51:42], want.row);
                    if (m_tlast != want.last) report("last_cell", m_tlast, want.last);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sfds_pkg::REG_FRAME_WIDTH:     frame_w = val[10:0];
            sfds_pkg::REG_FRAME_HEIGHT:    frame_h = val[10:0];
            sfds_pkg::REG_INV_SPACING_X:   inv_dx = val;
            sfds_pkg::REG_INV_SPACING_Y:   inv_dy = val;
            sfds_pkg::REG_DENSITY_GRAVITY: rho_g = val[15:0];
            sfds_pkg::REG_MASK_ENABLE:     mask_on = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (cell_q.size() != 0 || s_tvalid || direction_q.size() != 0);
    endtask

    task automatic configure(logic [10:0] w, logic [10:0] h, logic [31:0] ix,
                             logic [31:0] iy, logic [15:0] rg, logic men);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_write(sfds_pkg::REG_FRAME_WIDTH, {21'd0, w});
        cfg_write(sfds_pkg::REG_FRAME_HEIGHT, {21'd0, h});
        cfg_write(sfds_pkg::REG_INV_SPACING_X, ix);
        cfg_write(sfds_pkg::REG_INV_SPACING_Y, iy);
        cfg_write(sfds_pkg::REG_DENSITY_GRAVITY, {16'd0, rg});
        cfg_write(sfds_pkg::REG_MASK_ENABLE, {31'd0, men});
    endtask

    function automatic logic [31:0] pick_word(int shape, int c, int r);
        case (shape)
            0: return $urandom();
            1: return 32'(100000 + c * 1500 + r * 700 + $urandom_range(0, 4000));
            2: return 32'h0001_8000;
            default: return ((c + r) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_water(int shape);
        int r;
        if (shape != 1) return pick_word(shape, 0, 0);
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return -$urandom_range(1, 655360);
        return $urandom_range(1, 655360);
    endfunction

    // Queue one whole frame; a pause point of zero or more holds the sender
    // until everything queued so far has come back.
    task automatic queue_frame(int shape, int pause_at);
        int         w, h, k;
        cell_word_t wd;
        w = clamp_dim(frame_w);
        h = clamp_dim(frame_h);
        k = 0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (k == pause_at) wait_drained();
                wd.data[31:0] = pick_water(shape);
                wd.data[63:32] = pick_water(shape);
                wd.data[95:64] = pick_word(shape, c, r);
                wd.data[127:96] = (shape == 1)
                    ? 32'((c * 3 + r) * 65536 + $urandom_range(0, 65535))
                    : pick_word(shape, r, c);
                wd.flag = (shape == 3) ? 1'((c + r) % 2) : ($urandom_range(0, 7) == 0);
                cell_q.push_back(wd);
                k++;
            end
        end
    endtask

    initial begin
        int sent;
        int shape;
        logic [10:0] w, h;
        logic [31:0] ix, iy;
        logic [15:0] rg;
        wait (aresetn);
        @(posedge aclk);

        // Constant field: zero gradient everywhere.
        configure(11'd3, 11'd3, sfds_pkg::INV_SPACING_RESET, sfds_pkg::INV_SPACING_RESET,
                  sfds_pkg::DENSITY_GRAVITY_RESET, 1'b0);
        queue_frame(2, -1);
        // Extreme codes with masking on and top spacings, then with masking off, top x spacing and zero y spacing.
        configure(11'd3, 11'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        queue_frame(3, -1);
        configure(11'd0, 11'd1, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0);
        queue_frame(3, -1);
        configure(11'd4, 11'd2, 32'd1, 32'hFFFF_FFFF, 16'd1, 1'b0);
        queue_frame(0, 5);

        sent = 0;
        while (sent < 800) begin
            w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 12));
            h = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8));
            case ($urandom_range(0, 5))
                0: ix = 32'd0;
                1: ix = 32'hFFFF_FFFF;
                default: ix = $urandom();
            endcase
            iy = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom();
            rg = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom());
            configure(w, h, ix, iy, rg, 1'($urandom_range(0, 1)));
            no_gaps = ($urandom_range(0, 4) == 0);
            shape = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 3);
            queue_frame(shape, ($urandom_range(0, 7) == 0) ? 4 : -1);
            sent += clamp_dim(w) * clamp_dim(h);
        end
        no_gaps = 0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
